// File: design/cip_pkg.sv
// Package for the checked integer power block: word layouts, status codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies; compile first.
package cip_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int STATUS_W       = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_VALUE = 2'd1,
        ST_OVFL  = 2'd2
    } status_t;

    typedef struct packed {
        logic               mode;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  power;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decide;
        logic mul;
        logic check;
        logic publish;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic special;
        logic over;
        logic last_iter;
        logic mul_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/cip_stream_if.sv
// Valid/ready stream interface carrying one payload word per handshake.
// The payload type is a parameter; the word types come from cip_pkg.
interface cip_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/cip_ctrl.sv
// Controller state machine of the checked integer power block.
// Sequences load, classification, the multiply/check loop and result hand-off; uses cip_pkg.
module cip_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cip_pkg::dp_status_t stat,
    output cip_pkg::ctrl_cmd_t  cmd
);
    import cip_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_MUL    = 5'b00100,
        S_CHK    = 5'b01000,
        S_FIN    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.special ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.check  = 1'b1;
                state_next = (stat.over || stat.last_iter) ? S_FIN : S_MUL;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/cip_datapath.sv
// Datapath of the checked integer power block: operand registers, special-case
// classification, chunked multiplier with overflow compare, and the output register.
// Uses cip_pkg.
module cip_datapath #(
    parameter int DATA_WIDTH = cip_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cip_pkg::in_word_t   in_word,
    input  cip_pkg::ctrl_cmd_t  cmd,
    output cip_pkg::dp_status_t stat,
    input  logic                out_ready,
    output logic                out_valid,
    output cip_pkg::out_word_t  out_word
);
    import cip_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam bit SPLIT = (W > 32);
    localparam int CW    = SPLIT ? (W + 1) / 2 : W;
    localparam int NC    = SPLIT ? 2 : 1;
    localparam int NK    = NC * NC;
    localparam int KW    = (NK > 1) ? $clog2(NK) : 1;
    localparam int AW    = NC * CW;
    localparam int PPW   = 2 * CW;
    localparam int PW    = 2 * AW;

    localparam logic [W-1:0]  UMAX     = '1;
    localparam logic [W-1:0]  SMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN_MAG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  ONE      = W'(1);
    localparam logic [KW-1:0] LAST_K   = KW'(NK - 1);

    function automatic logic [W-1:0] apply_sign(input logic [W-1:0] mag, input logic neg);
        apply_sign = neg ? (~mag + ONE) : mag;
    endfunction

    logic            mode_reg;
    logic [W-1:0]    base_reg;
    logic [W-1:0]    count_reg;
    logic [W-1:0]    zmag_reg;
    logic            zneg_reg;
    logic [W-1:0]    mag_reg;
    logic            xneg_reg;
    logic [KW-1:0]   chunk_reg;
    logic [KW-1:0]   chunk_next;
    logic [PPW-1:0]  pp_reg;
    logic [1:0]      sh_reg;
    logic [PW-1:0]   acc_reg;
    logic [W-1:0]    res_reg;
    status_t         st_reg;
    logic            out_valid_reg;
    out_word_t       out_word_reg;

    logic            base_neg;
    logic [W-1:0]    base_mag;
    logic            sp;
    logic [W-1:0]    sp_res;
    status_t         sp_st;
    logic [AW-1:0]   a_ext;
    logic [AW-1:0]   b_ext;
    logic            ci;
    logic            cj;
    logic [CW-1:0]   a_chunk;
    logic [CW-1:0]   b_chunk;
    logic [PPW-1:0]  pp_next;
    logic [PW-1:0]   shifted;
    logic [PW-1:0]   prod;
    logic [W-1:0]    limit;
    logic            over;
    logic [W-1:0]    new_zmag;
    logic            new_zneg;

    // Classification of the registered operands; count_reg still holds the exponent here.
    assign base_neg = mode_reg & base_reg[W-1];
    assign base_mag = base_neg ? (~base_reg + ONE) : base_reg;

    always_comb
    begin
        sp     = 1'b1;
        sp_res = ONE;
        sp_st  = ST_OK;
        if (mode_reg && count_reg[W-1])
        begin
            sp_st = ST_VALUE;
        end
        else if (count_reg == '0)
        begin
            sp_res = ONE;
        end
        else if (base_reg == '0)
        begin
            sp_res = '0;
        end
        else if (base_reg == ONE)
        begin
            sp_res = ONE;
        end
        else if (mode_reg && base_reg == UMAX)
        begin
            // A base of minus one alternates with the exponent's parity.
            sp_res = count_reg[0] ? UMAX : ONE;
        end
        else
        begin
            sp = 1'b0;
        end
    end

    // One chunk product per cycle; the shifted products are summed into acc_reg.
    assign a_ext   = AW'(zmag_reg);
    assign b_ext   = AW'(mag_reg);
    assign ci      = 1'(chunk_reg % NC);
    assign cj      = 1'(chunk_reg / NC);
    assign a_chunk = a_ext[ci * CW +: CW];
    assign b_chunk = b_ext[cj * CW +: CW];
    assign pp_next = PPW'(a_chunk) * PPW'(b_chunk);
    assign shifted = PW'(pp_reg) << (sh_reg * CW);
    assign prod    = acc_reg + shifted;

    // The product of magnitudes is over the limit exactly when the full-width product
    // exceeds the limit, which is chosen from the mode and the running sign.
    assign limit    = !mode_reg ? UMAX : (zneg_reg ? SMIN_MAG : SMAX);
    assign over     = prod > PW'(limit);
    assign new_zmag = prod[W-1:0];
    assign new_zneg = zneg_reg ^ xneg_reg;

    assign chunk_next = (chunk_reg == LAST_K) ? '0 : chunk_reg + KW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mul)
            begin
                chunk_reg <= chunk_next;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_word.mode;
            base_reg  <= W'(in_word.base);
            count_reg <= W'(in_word.exponent);
        end
        if (cmd.decide)
        begin
            zmag_reg <= ONE;
            zneg_reg <= 1'b0;
            mag_reg  <= base_mag;
            xneg_reg <= base_neg;
            res_reg  <= sp_res;
            st_reg   <= sp_st;
        end
        if (cmd.mul)
        begin
            pp_reg  <= pp_next;
            sh_reg  <= 2'(ci) + 2'(cj);
            acc_reg <= (chunk_reg == '0) ? '0 : prod;
        end
        if (cmd.check)
        begin
            if (over)
            begin
                res_reg <= apply_sign(zmag_reg, zneg_reg);
                st_reg  <= ST_OVFL;
            end
            else
            begin
                zmag_reg  <= new_zmag;
                zneg_reg  <= new_zneg;
                count_reg <= count_reg - ONE;
                res_reg   <= apply_sign(new_zmag, new_zneg);
                st_reg    <= ST_OK;
            end
        end
        if (cmd.publish)
        begin
            out_word_reg.power  <= FIELD_W'(res_reg);
            out_word_reg.status <= st_reg;
        end
    end

    assign stat.special   = sp;
    assign stat.over      = over;
    assign stat.last_iter = (count_reg == ONE);
    assign stat.mul_last  = (chunk_reg == LAST_K);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// File: design/checked_integer_power.sv
// Channel   | Dir  | Word                          | Handshake
// operand   | in   | mode, base[31:0], exponent    | valid/ready, taken when both high
// result    | out  | power[31:0], status[1:0]      | valid/ready, taken when both high
//
// One word at a time. Special cases (negative exponent and base -1 in signed mode, zero
// exponent, base 0, +1) go from decide straight to the result. Otherwise each loop step
// runs NK chunk products, where NK is 1 for DATA_WIDTH up to 32 and 4 above (chunked
// multiplier), then one check, and the loop runs at most DATA_WIDTH steps.
// The result register holds a finished word while the next operand is already taken;
// a stalled result only stops the block once the next result is ready.
// Reset clears the controller and the result valid flag; no clearing pass is needed.
//
// Top level of the checked integer power block; uses cip_pkg, cip_stream_if,
// cip_ctrl and cip_datapath.
module checked_integer_power #(
    parameter int DATA_WIDTH = cip_pkg::DATA_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    cip_stream_if.sink   operand,
    cip_stream_if.source result
);
    import cip_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    logic       in_ready;
    logic       out_valid;
    out_word_t  out_word;
    in_word_t   in_word;

    assign in_word = operand.payload;

    cip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cip_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

    assign operand.ready  = in_ready;
    assign result.valid   = out_valid;
    assign result.payload = out_word;

endmodule
